>>> rtl/hslrgb_pkg.sv
`timescale 1ns / 1ps

package hslrgb_pkg;

  // Default fractional bits of saturation, lightness and the colour channels
  localparam int FRACTION_BITS = 12;

  // Field widths
  localparam int HUE_W  = 15;
  localparam int CH_W   = 13;
  localparam int FRAC_W = 12;   // offset of hue inside one 60 degree sector

  // Hue in 1/64 degree units
  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;

  // 3840 = 15 << 8: divide by 15 through a reciprocal after a shift of 8
  localparam int              DIV_SHIFT   = 8;
  localparam int              DIV_ODD     = 15;
  localparam int              RECIP_W     = 21;
  localparam int              RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP    = 21'd1118481;  // floor(2^24 / 15)

  typedef enum logic [2:0] {
    SECT_0 = 3'd0,
    SECT_1 = 3'd1,
    SECT_2 = 3'd2,
    SECT_3 = 3'd3,
    SECT_4 = 3'd4,
    SECT_5 = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  lightness;
  } hsl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

>>> rtl/hslrgb_div.sv
`timescale 1ns / 1ps

// Two-stage divide by one hue sector (3840): shift, reciprocal multiply,
// then one correction step.
module hslrgb_div #(
  parameter int FRACTION_BITS = hslrgb_pkg::FRACTION_BITS
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic [FRACTION_BITS+hslrgb_pkg::FRAC_W:0] prod_i,
  output logic [FRACTION_BITS:0]                   quot_o
);

  localparam int VW = FRACTION_BITS + 1;
  localparam int QW = VW + hslrgb_pkg::FRAC_W - hslrgb_pkg::DIV_SHIFT;
  localparam int MW = QW + hslrgb_pkg::RECIP_W;
  localparam int EW = QW + 4;

  logic [QW-1:0] q;
  logic [MW-1:0] mul;
  logic [QW-1:0] q_r, q_nxt;
  logic [QW-1:0] est_r, est_nxt;
  logic [EW-1:0] est15;
  logic [EW-1:0] rem;
  logic          fix;
  logic [VW-1:0] quot_r, quot_nxt;

  always_comb begin
    q       = QW'(prod_i >> hslrgb_pkg::DIV_SHIFT);
    mul     = MW'(q) * MW'(hslrgb_pkg::RECIP);
    q_nxt   = q;
    est_nxt = QW'(mul >> hslrgb_pkg::RECIP_SHIFT);
  end

  // estimate is low by at most one
  always_comb begin
    est15    = EW'(est_r) * EW'(hslrgb_pkg::DIV_ODD);
    rem      = EW'(q_r) - est15;
    fix      = (rem >= EW'(hslrgb_pkg::DIV_ODD));
    quot_nxt = VW'(est_r + QW'(fix));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= q_nxt;
      est_r  <= est_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign quot_o = quot_r;

endmodule

>>> rtl/hsl_to_rgb_converter_unit.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | hslrgb_pkg::hsl_t (hue, saturation, lightness)
// out_    | output    | out_valid/out_stall| hslrgb_pkg::rgb_t (red, green, blue)
//
// Six register stages; one pixel per clock while the output is not stalled.
// Throughput is set by the single shared pipeline enable: all stages move together.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// A stall on the output holds every stage; in_stall rises only while a
// result sits on the output and is being held off.
module hsl_to_rgb_converter_unit #(
  parameter int FRACTION_BITS = hslrgb_pkg::FRACTION_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hslrgb_pkg::hsl_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output hslrgb_pkg::rgb_t out_data
);

  localparam int VW = FRACTION_BITS + 1;   // holds 0..ONE
  localparam int CW = (VW > hslrgb_pkg::CH_W) ? VW : hslrgb_pkg::CH_W;
  localparam int PW = VW + hslrgb_pkg::FRAC_W;
  localparam int HW = hslrgb_pkg::HUE_W;
  localparam int FW = hslrgb_pkg::FRAC_W;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRACTION_BITS;
  localparam logic [VW:0]   ONE_T = (VW + 1)'(1) << FRACTION_BITS;
  localparam logic [VW-1:0] ONE_V = VW'(1) << FRACTION_BITS;

  // Pipeline control: every stage advances together unless a finished
  // result is held on the output.
  logic       en;
  logic [5:0] vld_r, vld_nxt;

  assign en       = !(vld_r[5] && out_stall);
  assign in_stall = !en;

  always_comb begin
    vld_nxt = {vld_r[4:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: input clamps, sector, and 1 - |2l - 1|
  logic [HW-1:0]       hue_s;
  logic [CW-1:0]       sat_e, lig_e;
  logic [VW-1:0]       sat_s, lig_s;
  logic [VW:0]         two_l, l_dev;
  hslrgb_pkg::sector_t sect;

  logic [HW-1:0]       s1_hue_r, s1_hue_nxt;
  hslrgb_pkg::sector_t s1_sector_r, s1_sector_nxt;
  logic [VW-1:0]       s1_sat_r, s1_sat_nxt;
  logic [VW-1:0]       s1_lig_r, s1_lig_nxt;
  logic [VW-1:0]       s1_omt_r, s1_omt_nxt;

  always_comb begin
    hue_s = (in_data.hue > hslrgb_pkg::HUE_FULL) ? hslrgb_pkg::HUE_FULL : in_data.hue;
    sat_e = CW'(in_data.saturation);
    lig_e = CW'(in_data.lightness);
    sat_s = VW'((sat_e > ONE_C) ? ONE_C : sat_e);
    lig_s = VW'((lig_e > ONE_C) ? ONE_C : lig_e);
    two_l = {lig_s, 1'b0};
    l_dev = (two_l >= ONE_T) ? (two_l - ONE_T) : (ONE_T - two_l);

    // hue of exactly 360 degrees falls in the last sector
    if (hue_s >= HW'(5 * hslrgb_pkg::HUE_SECTOR)) begin
      sect = hslrgb_pkg::SECT_5;
    end else if (hue_s >= HW'(4 * hslrgb_pkg::HUE_SECTOR)) begin
      sect = hslrgb_pkg::SECT_4;
    end else if (hue_s >= HW'(3 * hslrgb_pkg::HUE_SECTOR)) begin
      sect = hslrgb_pkg::SECT_3;
    end else if (hue_s >= HW'(2 * hslrgb_pkg::HUE_SECTOR)) begin
      sect = hslrgb_pkg::SECT_2;
    end else if (hue_s >= hslrgb_pkg::HUE_SECTOR) begin
      sect = hslrgb_pkg::SECT_1;
    end else begin
      sect = hslrgb_pkg::SECT_0;
    end

    s1_hue_nxt    = hue_s;
    s1_sector_nxt = sect;
    s1_sat_nxt    = sat_s;
    s1_lig_nxt    = lig_s;
    s1_omt_nxt    = VW'(ONE_T - l_dev);
  end

  // Stage 2: chroma product, offset inside the sector
  logic [2*VW-1:0]     cprod;
  logic [HW-1:0]       base;
  logic [FW-1:0]       frac;

  logic [VW-1:0]       s2_c_r, s2_c_nxt;
  logic [FW-1:0]       s2_k_r, s2_k_nxt;
  hslrgb_pkg::sector_t s2_sector_r;
  logic [VW-1:0]       s2_lig_r;

  always_comb begin
    cprod = (2 * VW)'(s1_omt_r) * (2 * VW)'(s1_sat_r);
    unique case (s1_sector_r)
      hslrgb_pkg::SECT_0: base = '0;
      hslrgb_pkg::SECT_1: base = hslrgb_pkg::HUE_SECTOR;
      hslrgb_pkg::SECT_2: base = HW'(2 * hslrgb_pkg::HUE_SECTOR);
      hslrgb_pkg::SECT_3: base = HW'(3 * hslrgb_pkg::HUE_SECTOR);
      hslrgb_pkg::SECT_4: base = HW'(4 * hslrgb_pkg::HUE_SECTOR);
      hslrgb_pkg::SECT_5: base = HW'(5 * hslrgb_pkg::HUE_SECTOR);
      default:            base = '0;
    endcase
    frac     = FW'(s1_hue_r - base);
    s2_c_nxt = VW'(cprod >> FRACTION_BITS);
    // falling edge of x on odd sectors
    case (s1_sector_r) inside
      hslrgb_pkg::SECT_1, hslrgb_pkg::SECT_3, hslrgb_pkg::SECT_5:
        s2_k_nxt = FW'(hslrgb_pkg::HUE_SECTOR) - frac;
      default:
        s2_k_nxt = frac;
    endcase
  end

  // Stage 3: c * k and the offset m
  logic [VW-1:0]       c_half;
  logic [PW-1:0]       s3_prod_r, s3_prod_nxt;
  logic [VW-1:0]       s3_m_r, s3_m_nxt;
  logic [VW-1:0]       s3_c_r;
  hslrgb_pkg::sector_t s3_sector_r;

  always_comb begin
    c_half      = s2_c_r >> 1;
    s3_prod_nxt = PW'(s2_c_r) * PW'(s2_k_r);
    s3_m_nxt    = (s2_lig_r >= c_half) ? (s2_lig_r - c_half) : '0;
  end

  // Stages 4 and 5: x = c * k / 3840
  logic [VW-1:0] s5_x;

  hslrgb_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk    (clk),
    .en     (en),
    .prod_i (s3_prod_r),
    .quot_o (s5_x)
  );

  logic [VW-1:0]       s4_c_r, s4_m_r, s5_c_r, s5_m_r;
  hslrgb_pkg::sector_t s4_sector_r, s5_sector_r;

  // Stage 6: place c and x, add m, clamp to one
  logic [VW-1:0]    r_v, g_v, b_v;
  logic [VW:0]      r_sum, g_sum, b_sum;
  hslrgb_pkg::rgb_t out_r, out_nxt;

  always_comb begin
    r_v = '0;
    g_v = '0;
    b_v = '0;
    unique case (s5_sector_r)
      hslrgb_pkg::SECT_0: begin r_v = s5_c_r; g_v = s5_x;   end
      hslrgb_pkg::SECT_1: begin r_v = s5_x;   g_v = s5_c_r; end
      hslrgb_pkg::SECT_2: begin g_v = s5_c_r; b_v = s5_x;   end
      hslrgb_pkg::SECT_3: begin g_v = s5_x;   b_v = s5_c_r; end
      hslrgb_pkg::SECT_4: begin r_v = s5_x;   b_v = s5_c_r; end
      default:            begin r_v = s5_c_r; b_v = s5_x;   end
    endcase
    r_sum = (VW + 1)'(r_v) + (VW + 1)'(s5_m_r);
    g_sum = (VW + 1)'(g_v) + (VW + 1)'(s5_m_r);
    b_sum = (VW + 1)'(b_v) + (VW + 1)'(s5_m_r);
    // clamp is a guard only; above 12 fractional bits the field wraps
    out_nxt.red   = hslrgb_pkg::CH_W'((r_sum > ONE_T) ? ONE_V : VW'(r_sum));
    out_nxt.green = hslrgb_pkg::CH_W'((g_sum > ONE_T) ? ONE_V : VW'(g_sum));
    out_nxt.blue  = hslrgb_pkg::CH_W'((b_sum > ONE_T) ? ONE_V : VW'(b_sum));
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      s1_hue_r    <= s1_hue_nxt;
      s1_sector_r <= s1_sector_nxt;
      s1_sat_r    <= s1_sat_nxt;
      s1_lig_r    <= s1_lig_nxt;
      s1_omt_r    <= s1_omt_nxt;

      s2_c_r      <= s2_c_nxt;
      s2_k_r      <= s2_k_nxt;
      s2_sector_r <= s1_sector_r;
      s2_lig_r    <= s1_lig_r;

      s3_prod_r   <= s3_prod_nxt;
      s3_m_r      <= s3_m_nxt;
      s3_c_r      <= s2_c_r;
      s3_sector_r <= s2_sector_r;

      s4_c_r      <= s3_c_r;
      s4_m_r      <= s3_m_r;
      s4_sector_r <= s3_sector_r;

      s5_c_r      <= s4_c_r;
      s5_m_r      <= s4_m_r;
      s5_sector_r <= s4_sector_r;

      out_r       <= out_nxt;
    end
  end

  assign out_valid = vld_r[5];
  assign out_data  = out_r;

  // Checks
  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted transfer not in first stage");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_hold_valids : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("stage valids moved during stall");

  a_x_below_c : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (s5_x <= s5_c_r))
    else $error("sector divide result exceeds chroma");

endmodule

>>> tb/hsl_rgb_pixel_checker.sv
`timescale 1ns / 1ps

module hsl_rgb_pixel_checker #(
  parameter int FRACTION_BITS = hslrgb_pkg::FRACTION_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  hslrgb_pkg::hsl_t in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  hslrgb_pkg::rgb_t out_data,
  output int               fail_count,
  output int               pending
);

  localparam logic [63:0] UNIT = 64'd1 << FRACTION_BITS;

  hslrgb_pkg::rgb_t rgb_due[$];
  hslrgb_pkg::rgb_t rgb_exp;
  int               fails = 0;

  function automatic logic [63:0] clamp_unit(logic [63:0] v);
    return (v > UNIT) ? UNIT : v;
  endfunction

  function automatic hslrgb_pkg::rgb_t hsl_to_rgb(hslrgb_pkg::hsl_t px);
    logic [63:0] hue, sat, lig, two_l, l_dev, chroma, idx, offs, k, side, base;
    logic [63:0] r, g, b;
    hslrgb_pkg::sector_t sect;
    hslrgb_pkg::rgb_t    res;
    hue = 64'(px.hue);
    if (hue > hslrgb_pkg::HUE_FULL) hue = 64'(hslrgb_pkg::HUE_FULL);
    sat = clamp_unit(64'(px.saturation));
    lig = clamp_unit(64'(px.lightness));
    two_l  = lig << 1;
    l_dev  = (two_l >= UNIT) ? (two_l - UNIT) : (UNIT - two_l);
    chroma = ((UNIT - l_dev) * sat) >> FRACTION_BITS;
    idx = hue / hslrgb_pkg::HUE_SECTOR;
    if (idx > 5) idx = 5;   // hue of a full turn stays in the last sector
    sect = hslrgb_pkg::sector_t'(idx[2:0]);
    offs = hue - idx * hslrgb_pkg::HUE_SECTOR;
    k    = idx[0] ? (hslrgb_pkg::HUE_SECTOR - offs) : offs;
    side = (chroma * k) / hslrgb_pkg::HUE_SECTOR;
    base = (lig >= (chroma >> 1)) ? (lig - (chroma >> 1)) : 64'd0;
    r = 0;
    g = 0;
    b = 0;
    case (sect)
      hslrgb_pkg::SECT_0: begin r = chroma; g = side; end
      hslrgb_pkg::SECT_1: begin r = side; g = chroma; end
      hslrgb_pkg::SECT_2: begin g = chroma; b = side; end
      hslrgb_pkg::SECT_3: begin g = side; b = chroma; end
      hslrgb_pkg::SECT_4: begin r = side; b = chroma; end
      default: begin r = chroma; b = side; end
    endcase
    res.red   = hslrgb_pkg::CH_W'(clamp_unit(r + base));
    res.green = hslrgb_pkg::CH_W'(clamp_unit(g + base));
    res.blue  = hslrgb_pkg::CH_W'(clamp_unit(b + base));
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (rgb_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                     out_data.red, out_data.green, out_data.blue);
        end else begin
          rgb_exp = rgb_due.pop_front();
          if (rgb_exp.red !== out_data.red || rgb_exp.green !== out_data.green ||
              rgb_exp.blue !== out_data.blue) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, rgb_exp.red, rgb_exp.green, rgb_exp.blue,
                       out_data.red, out_data.green, out_data.blue);
          end
        end
      end
      if (in_valid && !in_stall) rgb_due.push_back(hsl_to_rgb(in_data));
    end
    fail_count <= fails;
    pending    <= rgb_due.size();
  end

endmodule

>>> tb/tb_hsl_to_rgb_converter_unit.sv
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter_unit;

  localparam int RANDOM_PIXELS = 600;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  hslrgb_pkg::hsl_t in_data = '0;
  logic in_stall;
  logic out_valid;
  hslrgb_pkg::rgb_t out_data;
  int   fail_count;
  int   pending;
  bit   burst = 1'b0;   // sender offers back to back while set

  always #2 clk = ~clk;

  hsl_to_rgb_converter_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  hsl_rgb_pixel_checker i_pixel_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Idle length: mostly none or short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // One pixel transfer; valid only drops when a gap is actually taken, so the
  // line is never lowered and raised again within one edge
  task automatic send_pixel(input int unsigned h, input int unsigned s,
                            input int unsigned l);
    int unsigned      gap;
    hslrgb_pkg::hsl_t px;
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data  <= '{hue: 15'($urandom), saturation: 13'($urandom),
                    lightness: 13'($urandom)};
      repeat (gap) @(posedge clk);
    end
    px.hue        = h[hslrgb_pkg::HUE_W-1:0];
    px.saturation = s[hslrgb_pkg::CH_W-1:0];
    px.lightness  = l[hslrgb_pkg::CH_W-1:0];
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver: random holds, quiet stretches, and one long hold-off early on
  // so the pipeline fills and the stall reaches the input side
  initial begin : receiver
    int unsigned free_run;
    int unsigned hold;
    int unsigned cycles;
    bit          held_off;
    cycles   = 0;
    held_off = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      free_run = 1 + idle_len();
      if ($urandom_range(0, 9) == 0) free_run += 100;
      out_stall <= 1'b0;
      repeat (free_run) @(posedge clk);
      cycles += free_run;
      hold = idle_len();
      if (!held_off && cycles > 150) begin
        hold     = 80;
        held_off = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        cycles += hold;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int unsigned h;
    int unsigned s;
    int unsigned l;
    int unsigned r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Primary and secondary hues at full saturation, mid lightness
    send_pixel(0,     4096, 2048);
    send_pixel(3840,  4096, 2048);
    send_pixel(7680,  4096, 2048);
    send_pixel(11520, 4096, 2048);
    send_pixel(15360, 4096, 2048);
    send_pixel(19200, 4096, 2048);
    // Full turn wraps onto red via the last sector
    send_pixel(23040, 4096, 2048);
    // Sector edges and middles
    send_pixel(3839,  4096, 2048);
    send_pixel(1920,  4096, 2048);
    send_pixel(5760,  4096, 2048);
    send_pixel(23039, 3000, 2500);
    // Hue beyond a full turn is clamped
    send_pixel(23041, 4096, 2048);
    send_pixel(32767, 4096, 2048);
    // Grey, black, white
    send_pixel(9000,  0,    2048);
    send_pixel(9000,  4096, 0);
    send_pixel(9000,  4096, 4096);
    // Saturation and lightness above unity are clamped
    send_pixel(9000,  8191, 2048);
    send_pixel(9000,  4096, 8191);
    send_pixel(32767, 8191, 8191);
    send_pixel(0,     0,    0);
    // Lightness near the ends and just past the midpoint
    send_pixel(13000, 4096, 1);
    send_pixel(13000, 4096, 4095);
    send_pixel(13000, 1,    2049);
    send_pixel(17000, 2500, 1000);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      // Switch between back-to-back bursts and gappy traffic every 50 pixels
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 80)
        h = $urandom_range(0, hslrgb_pkg::HUE_FULL);
      else if (r < 90)
        h = $urandom_range(0, 6) * hslrgb_pkg::HUE_SECTOR + $urandom_range(0, 2) - 1;
      else
        h = $urandom_range(hslrgb_pkg::HUE_FULL + 1, 32767);
      if (h > 32767) h = 0;   // below-zero edge pick folds back onto zero
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(4097, 8191) : $urandom_range(0, 4096);
      l = ($urandom_range(0, 9) == 0) ? $urandom_range(4097, 8191) : $urandom_range(0, 4096);
      send_pixel(h, s, l);
    end
    in_valid <= 1'b0;

    // let the count take in the last transfer before waiting on it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Six stages: give any stray result time to show up
    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, well above the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
